// ===== rtl/eho_pkg.sv =====
// Package for the encoder heading odometry unit: field widths, fixed-point
// constants, function codes, CORDIC request/response types, arctangent table.
// No dependencies.
`default_nettype none

package eho_pkg;

    // Defaults for the top-level parameters
    localparam int POSITION_WIDTH_DEF = 32;
    localparam int CORDIC_STEPS_DEF   = 16;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int POS_IN_W = 32;
    localparam int HEAD_W   = 15;
    localparam int ACC_W    = 32;
    localparam int SCALE_W  = 16;

    // Datapath widths
    localparam int DIST_W  = 48;  // saturated change times Q16 scale
    localparam int TRIG_W  = 17;  // rounded Q15 sin / cos
    localparam int PROD_W  = 63;  // distance times trig, kept modulo 2^63
    localparam int Q30_W   = 32;  // CORDIC x / y
    localparam int Z_W     = 26;  // CORDIC angle, degrees times 65536
    localparam int ATAN_W  = 23;
    localparam int ANGLE_W = 16;  // folded heading, 1/64 degree
    localparam int CNT_W   = 5;

    localparam logic [CNT_W-1:0] DIST_STEPS = CNT_W'(SCALE_W);
    localparam logic [CNT_W-1:0] MUL_LAST   = CNT_W'(TRIG_W - 1);

    localparam logic [SCALE_W-1:0]      SCALE_RESET     = 16'd15807;
    localparam logic signed [Q30_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [Q30_W-1:0] ROUND_Q15       = 32'sd16384;
    localparam logic [PROD_W-1:0]       PROD_ROUND      = {32'd0, 1'b1, 30'd0};

    // Heading turns in 1/64 degree
    localparam logic signed [ANGLE_W-1:0] FULL_TURN         = 16'sd23040;
    localparam logic signed [ANGLE_W-1:0] HALF_TURN         = 16'sd11520;
    localparam logic signed [ANGLE_W-1:0] NEG_HALF_TURN     = -16'sd11520;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN      = 16'sd5760;
    localparam logic signed [ANGLE_W-1:0] NEG_QUARTER_TURN  = -16'sd5760;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK = 2'd0,
        FUNC_SET  = 2'd1,
        FUNC_ZERO = 2'd2
    } t_func;

    typedef struct packed {
        logic                     start;
        logic signed [HEAD_W-1:0] heading;
    } t_cordic_req;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] sin_q15;
        logic signed [TRIG_W-1:0] cos_q15;
    } t_cordic_rsp;

    // atan(2^-i) in degrees times 65536
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/eho_if.sv =====
// Valid/ready channel interfaces of the encoder heading odometry unit:
// the input word (tick, set, zero) and the pose result word. Uses eho_pkg.
`default_nettype none

interface eho_in_if import eho_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [POS_IN_W-1:0] left_position;
    logic signed [POS_IN_W-1:0] right_position;
    logic signed [HEAD_W-1:0]   heading;
    logic signed [ACC_W-1:0]    new_x;
    logic signed [ACC_W-1:0]    new_y;
    logic                       set_x;
    logic                       set_y;
    logic                       set_heading;

    modport source (
        output valid, func, left_position, right_position, heading,
               new_x, new_y, set_x, set_y, set_heading,
        input  ready
    );

    modport sink (
        input  valid, func, left_position, right_position, heading,
               new_x, new_y, set_x, set_y, set_heading,
        output ready
    );
endinterface

interface eho_out_if import eho_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  x_pos;
    logic signed [ACC_W-1:0]  y_pos;
    logic signed [HEAD_W-1:0] heading_out;

    modport source (
        output valid, x_pos, y_pos, heading_out,
        input  ready
    );

    modport sink (
        input  valid, x_pos, y_pos, heading_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/eho_cordic.sv =====
// Iterative rotation-mode CORDIC: folds a heading into +-90 degrees and
// returns rounded Q15 sin and cos, one micro-rotation per cycle. Uses eho_pkg.
`default_nettype none

module eho_cordic import eho_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);

    localparam int IT_W = $clog2(CORDIC_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROT,
        S_FIX,
        S_RND
    } t_state;

    t_state                   r_state;
    logic [IT_W-1:0]          r_cnt;
    logic signed [Q30_W-1:0]  r_x;
    logic signed [Q30_W-1:0]  r_y;
    logic signed [Z_W-1:0]    r_z;
    logic                     r_neg;
    t_cordic_rsp              r_rsp;

    logic signed [ANGLE_W-1:0] h0;
    logic signed [ANGLE_W-1:0] h1;
    logic signed [ANGLE_W-1:0] h2;
    logic                      fold_neg;
    logic signed [Z_W-1:0]     z0;

    logic signed [Q30_W-1:0] xs;
    logic signed [Q30_W-1:0] ys;
    logic signed [Z_W-1:0]   at;
    logic signed [Q30_W-1:0] n_x;
    logic signed [Q30_W-1:0] n_y;
    logic signed [Z_W-1:0]   n_z;
    logic signed [Q30_W-1:0] rnd_x;
    logic signed [Q30_W-1:0] rnd_y;

    // Fold the heading into one turn, then into the right half plane
    always_comb begin
        h0 = {i_req.heading[HEAD_W-1], i_req.heading};
        h1 = h0;
        if (h0 > HALF_TURN) begin
            h1 = h0 - FULL_TURN;
        end else if (h0 < NEG_HALF_TURN) begin
            h1 = h0 + FULL_TURN;
        end
        h2       = h1;
        fold_neg = 1'b0;
        if (h1 > QUARTER_TURN) begin
            h2       = h1 - HALF_TURN;
            fold_neg = 1'b1;
        end else if (h1 < NEG_QUARTER_TURN) begin
            h2       = h1 + HALF_TURN;
            fold_neg = 1'b1;
        end
        z0 = {h2, 10'd0};
    end

    // One micro-rotation, direction from the sign of the residual angle
    always_comb begin
        xs = r_x >>> r_cnt;
        ys = r_y >>> r_cnt;
        at = {{(Z_W - ATAN_W){1'b0}}, atan_entry(5'(r_cnt))};
        if (!r_z[Z_W-1]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - at;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + at;
        end
        rnd_x = r_x + ROUND_Q15;
        rnd_y = r_y + ROUND_Q15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_rsp.done <= 1'b0;
        end else begin
            r_rsp.done <= (r_state == S_RND);
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_x     <= CORDIC_GAIN_Q30;
                        r_y     <= '0;
                        r_z     <= z0;
                        r_neg   <= fold_neg;
                        r_cnt   <= '0;
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    if (r_cnt == IT_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_FIX;
                    end else begin
                        r_cnt <= r_cnt + IT_W'(1);
                    end
                end
                S_FIX: begin
                    // undo the half-turn fold
                    if (r_neg) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                    end
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_rsp.cos_q15 <= rnd_x[Q30_W-1 -: TRIG_W];
                    r_rsp.sin_q15 <= rnd_y[Q30_W-1 -: TRIG_W];
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// ===== rtl/encoder_heading_odometry_unit.sv =====
// Encoder heading odometry unit: dead-reckoning pose from two drive encoders
// and an absolute heading. Uses eho_pkg, eho_in_if / eho_out_if, eho_cordic.
//
// Channels: i_in carries one input word (func tick / set / zero, encoder
// positions, heading, new pose parts); o_out carries one pose word (x, y,
// heading) for every input word. Both are valid/ready; a word moves on a
// clock edge with valid and ready high. i_cfg_we / i_cfg_wdata write the Q16
// distance scale; write it only while no word is in flight.
// Flow: a tick passes the offset and change states, then the CORDIC rotator
// with the distance multiply running beside it, then a bit-serial trig
// multiply and the accumulate state before its pose is loaded; the next word
// can be taken in the cycle after the result is loaded. Set and zero words
// go through the apply state instead.
// Ready is high only while the unit is idle. A finished pose waits in the
// output register; while the receiver stalls the unit holds the next pose in
// its last state and accepts nothing new.
// Reset (synchronous, active low) clears x, y, heading, the encoder offset and
// the previous sum, sets the scale to its default and drops o_out.valid.
`default_nettype none

module encoder_heading_odometry_unit import eho_pkg::*; #(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_wdata,
    eho_in_if.sink             i_in,
    eho_out_if.source          o_out
);

    localparam int SUM_W = POSITION_WIDTH + 1;
    localparam int EXT_W = (SUM_W > 32) ? SUM_W : 33;

    localparam logic signed [EXT_W-1:0] CHG_MAX = EXT_W'(signed'(32'h7fff_ffff));
    localparam logic signed [EXT_W-1:0] CHG_MIN = EXT_W'(signed'(32'h8000_0000));

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_REL,
        S_CHG,
        S_ROT,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    t_state r_state;

    // Architectural state
    logic [SCALE_W-1:0] r_scale;
    logic [ACC_W-1:0]   r_x_acc;
    logic [ACC_W-1:0]   r_y_acc;
    logic [HEAD_W-1:0]  r_heading_acc;
    logic [SUM_W-1:0]   r_prev;
    logic [SUM_W-1:0]   r_offset;

    // Latched input word
    logic [FUNC_W-1:0] r_func;
    logic [HEAD_W-1:0] r_heading;
    logic [ACC_W-1:0]  r_new_x;
    logic [ACC_W-1:0]  r_new_y;
    logic              r_set_x;
    logic              r_set_y;
    logic              r_set_heading;

    // Datapath
    logic [SUM_W-1:0]         r_sum;
    logic [SUM_W-1:0]         r_rel;
    logic [CNT_W-1:0]         r_cnt;
    logic [DIST_W-1:0]        r_dcand;
    logic signed [DIST_W-1:0] r_dist;
    logic [SCALE_W-1:0]       r_scl_sh;
    logic [PROD_W-1:0]        r_mcand;
    logic [PROD_W-1:0]        r_prod_x;
    logic [PROD_W-1:0]        r_prod_y;
    logic [TRIG_W-1:0]        r_tx_sh;
    logic [TRIG_W-1:0]        r_ty_sh;
    logic                     r_trig_ok;
    logic                     r_cor_start;

    // Output register
    logic              r_out_valid;
    logic [ACC_W-1:0]  r_out_x;
    logic [ACC_W-1:0]  r_out_y;
    logic [HEAD_W-1:0] r_out_heading;

    logic signed [POSITION_WIDTH-1:0] lp_pw;
    logic signed [POSITION_WIDTH-1:0] rp_pw;
    logic [SUM_W-1:0]                 n_sum;
    logic [SUM_W-1:0]                 n_rel;
    logic [SUM_W-1:0]                 n_delta;
    logic signed [EXT_W-1:0]          chg_ext;
    logic signed [ACC_W-1:0]          n_chg;
    logic signed [DIST_W-1:0]         n_dist;
    logic [PROD_W-1:0]                add_x;
    logic [PROD_W-1:0]                add_y;
    logic [PROD_W-1:0]                n_prod_x;
    logic [PROD_W-1:0]                n_prod_y;

    t_cordic_req w_req;
    t_cordic_rsp w_rsp;

    assign lp_pw = POSITION_WIDTH'(i_in.left_position);
    assign rp_pw = POSITION_WIDTH'(i_in.right_position);

    always_comb begin
        // encoder sum, offset removal and change all wrap at SUM_W bits
        n_sum   = SUM_W'(lp_pw) + SUM_W'(rp_pw);
        n_rel   = r_sum - r_offset;
        n_delta = r_rel - r_prev;
        chg_ext = EXT_W'(signed'(n_delta));
        // clamp the change to the 32-bit signed range before scaling
        if (chg_ext > CHG_MAX) begin
            n_chg = CHG_MAX[ACC_W-1:0];
        end else if (chg_ext < CHG_MIN) begin
            n_chg = CHG_MIN[ACC_W-1:0];
        end else begin
            n_chg = chg_ext[ACC_W-1:0];
        end

        // distance: one scale bit per cycle, unsigned multiplier
        n_dist = r_dist + (r_scl_sh[0] ? r_dcand : '0);

        // distance times trig: one trig bit per cycle, the top bit weighs negative
        add_x = r_tx_sh[0] ? r_mcand : '0;
        add_y = r_ty_sh[0] ? r_mcand : '0;
        if (r_cnt == MUL_LAST) begin
            n_prod_x = r_prod_x - add_x;
            n_prod_y = r_prod_y - add_y;
        end else begin
            n_prod_x = r_prod_x + add_x;
            n_prod_y = r_prod_y + add_y;
        end
    end

    assign w_req.start   = r_cor_start;
    assign w_req.heading = r_heading;

    eho_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_cor_start   <= 1'b0;
            r_trig_ok     <= 1'b0;
            r_cnt         <= '0;
            r_scale       <= SCALE_RESET;
            r_x_acc       <= '0;
            r_y_acc       <= '0;
            r_heading_acc <= '0;
            r_prev        <= '0;
            r_offset      <= '0;
        end else begin
            // kick the rotator as the change is taken
            r_cor_start <= (r_state == S_CHG);
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            // drop the result word once the receiver takes it
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_sum         <= n_sum;
                        r_func        <= i_in.func;
                        r_heading     <= i_in.heading;
                        r_new_x       <= i_in.new_x;
                        r_new_y       <= i_in.new_y;
                        r_set_x       <= i_in.set_x;
                        r_set_y       <= i_in.set_y;
                        r_set_heading <= i_in.set_heading;
                        r_state       <= (i_in.func == FUNC_TICK) ? S_REL : S_APPLY;
                    end
                end
                S_APPLY: begin
                    case (r_func)
                        FUNC_SET: begin
                            if (r_set_x) begin
                                r_x_acc <= r_new_x;
                            end
                            if (r_set_y) begin
                                r_y_acc <= r_new_y;
                            end
                            if (r_set_heading) begin
                                r_heading_acc <= r_heading;
                            end
                        end
                        FUNC_ZERO: begin
                            // capture the offset and restart the change history
                            r_offset <= r_sum;
                            r_prev   <= '0;
                        end
                        default: ;
                    endcase
                    r_state <= S_DONE;
                end
                S_REL: begin
                    r_rel   <= n_rel;
                    r_state <= S_CHG;
                end
                S_CHG: begin
                    r_prev      <= r_rel;
                    r_dcand     <= DIST_W'(n_chg);
                    r_dist      <= '0;
                    r_scl_sh    <= r_scale;
                    r_cnt       <= '0;
                    r_trig_ok   <= 1'b0;
                    r_state     <= S_ROT;
                end
                S_ROT: begin
                    // hold sin / cos in the multiplier shift registers
                    if (w_rsp.done) begin
                        r_tx_sh   <= w_rsp.sin_q15;
                        r_ty_sh   <= w_rsp.cos_q15;
                        r_trig_ok <= 1'b1;
                    end
                    if (r_cnt != DIST_STEPS) begin
                        r_dist   <= n_dist;
                        r_dcand  <= r_dcand << 1;
                        r_scl_sh <= r_scl_sh >> 1;
                        r_cnt    <= r_cnt + CNT_W'(1);
                    end else if (r_trig_ok) begin
                        // preload the half-LSB so the step rounds half up
                        r_prod_x <= PROD_ROUND;
                        r_prod_y <= PROD_ROUND;
                        r_mcand  <= PROD_W'(r_dist);
                        r_cnt    <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod_x <= n_prod_x;
                    r_prod_y <= n_prod_y;
                    r_mcand  <= r_mcand << 1;
                    r_tx_sh  <= r_tx_sh >> 1;
                    r_ty_sh  <= r_ty_sh >> 1;
                    if (r_cnt == MUL_LAST) begin
                        r_state <= S_ACC;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_ACC: begin
                    // the step is the product shifted right by 31, wrapped to 32 bits
                    r_x_acc       <= r_x_acc + r_prod_x[PROD_W-1 -: ACC_W];
                    r_y_acc       <= r_y_acc + r_prod_y[PROD_W-1 -: ACC_W];
                    r_heading_acc <= r_heading;
                    r_state       <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_x       <= r_x_acc;
                        r_out_y       <= r_y_acc;
                        r_out_heading <= r_heading_acc;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.x_pos       = r_out_x;
    assign o_out.y_pos       = r_out_y;
    assign o_out.heading_out = r_out_heading;

`ifndef NO_ASSERTIONS
    // The rotator answers only while a tick waits for it, and only once
    a_trig_in_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_ROT && !r_trig_ok))
        else $error("CORDIC result outside the rotate phase");

    // The trig multiply never starts without sin and cos loaded
    a_mul_has_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> r_trig_ok)
        else $error("trig multiply running without CORDIC result");

    // Step counter stays within the longest serial pass
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DIST_STEPS)
        else $error("serial step counter out of range");

    // A result word appears only when an item finishes
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word raised outside the finish state");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for encoder_heading_odometry_unit: drives tick, set, zero and spare
// words, predicts every pose word and checks them in order. Uses eho_pkg,
// eho_in_if / eho_out_if and the unit's RTL.
`default_nettype none

module tb_top;
    import eho_pkg::*;

    // Spare function code: the unit must leave its state alone
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // Heading turns in 1/64 degree and CORDIC start value (Q30, gain corrected)
    localparam longint DEG_FULL    = 23040;
    localparam longint DEG_HALF    = 11520;
    localparam longint DEG_QUARTER = 5760;
    localparam longint GAIN_Q30    = 652032874;
    localparam int     ROTATIONS   = CORDIC_STEPS_DEF;

    localparam longint CHANGE_MAX = 64'sd2147483647;
    localparam longint CHANGE_MIN = -64'sd2147483648;

    localparam int STALL_LONG   = 400;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [POS_IN_W-1:0] lp;
        logic [POS_IN_W-1:0] rp;
        logic [HEAD_W-1:0]   hd;
        logic [ACC_W-1:0]    nx;
        logic [ACC_W-1:0]    ny;
        logic                sx;
        logic                sy;
        logic                sh;
    } t_odo_word;

    typedef struct packed {
        logic [ACC_W-1:0]  x;
        logic [ACC_W-1:0]  y;
        logic [HEAD_W-1:0] hd;
    } t_pose;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [SCALE_W-1:0] i_cfg_wdata;

    eho_in_if  in_ch ();
    eho_out_if out_ch ();

    encoder_heading_odometry_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // atan(2^-i) in degrees times 65536
    longint atan_deg16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // Predictor copy of the unit's state and scale register
    logic [SCALE_W-1:0] scale_model;
    logic [ACC_W-1:0]   x_model;
    logic [ACC_W-1:0]   y_model;
    logic [HEAD_W-1:0]  heading_model;
    logic [POS_IN_W:0]  last_sum;
    logic [POS_IN_W:0]  base_sum;

    // Running encoder positions for realistic motion
    logic [POS_IN_W-1:0] enc_left;
    logic [POS_IN_W-1:0] enc_right;

    t_pose pending_poses [$];
    int    pose_mismatches;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    stall_request;

    //------------------------------------------------------------------
    // Clock, limit
    //------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("encoder_heading_odometry_unit verification failed");
        $finish;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // Rotation-mode CORDIC, results rounded half up to Q15
    function automatic void trig_q15(input logic signed [HEAD_W-1:0] hd,
                                     output longint s_q15, output longint c_q15);
        longint h, xv, yv, zv, xs, ys;
        bit     flip;
        int     i;
        h    = hd;
        flip = 1'b0;
        // fold into +-180 degrees, then into +-90 with a sign flip
        if (h > DEG_HALF) h -= DEG_FULL;
        if (h < -DEG_HALF) h += DEG_FULL;
        if (h > DEG_QUARTER) begin
            h -= DEG_HALF;
            flip = 1'b1;
        end else if (h < -DEG_QUARTER) begin
            h += DEG_HALF;
            flip = 1'b1;
        end
        xv = GAIN_Q30;
        yv = 0;
        zv = h * 1024;
        for (i = 0; i < ROTATIONS; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (zv >= 0) begin
                xv -= ys;
                yv += xs;
                zv -= atan_deg16[i];
            end else begin
                xv += ys;
                yv -= xs;
                zv += atan_deg16[i];
            end
        end
        if (flip) begin
            xv = -xv;
            yv = -yv;
        end
        c_q15 = (xv + 16384) >>> 15;
        s_q15 = (yv + 16384) >>> 15;
    endfunction

    // Apply one word to the predictor state and return the pose it reports
    function automatic t_pose advance_pose(input t_odo_word w);
        logic [POS_IN_W:0] enc_sum;
        logic [POS_IN_W:0] rel;
        logic [POS_IN_W:0] diff;
        longint chg, travel, s_q15, c_q15, step;
        t_pose  p;
        enc_sum = {w.lp[POS_IN_W-1], w.lp} + {w.rp[POS_IN_W-1], w.rp};
        case (w.func)
            FUNC_TICK: begin
                rel      = enc_sum - base_sum;
                diff     = rel - last_sum;
                last_sum = rel;
                chg      = longint'($signed(diff));
                if (chg > CHANGE_MAX) chg = CHANGE_MAX;
                if (chg < CHANGE_MIN) chg = CHANGE_MIN;
                travel = chg * longint'(scale_model);
                trig_q15(w.hd, s_q15, c_q15);
                step    = (travel * s_q15 + (longint'(1) << 30)) >>> 31;
                x_model = x_model + step[ACC_W-1:0];
                step    = (travel * c_q15 + (longint'(1) << 30)) >>> 31;
                y_model = y_model + step[ACC_W-1:0];
                heading_model = w.hd;
            end
            FUNC_SET: begin
                if (w.sx) x_model = w.nx;
                if (w.sy) y_model = w.ny;
                if (w.sh) heading_model = w.hd;
            end
            FUNC_ZERO: begin
                base_sum = enc_sum;
                last_sum = '0;
            end
            default: begin
            end
        endcase
        p.x  = x_model;
        p.y  = y_model;
        p.hd = heading_model;
        return p;
    endfunction

    //------------------------------------------------------------------
    // Word builders
    //------------------------------------------------------------------
    function automatic t_odo_word mk_word(input logic [FUNC_W-1:0] func,
                                          input logic [POS_IN_W-1:0] lp,
                                          input logic [POS_IN_W-1:0] rp,
                                          input logic [HEAD_W-1:0] hd,
                                          input logic [ACC_W-1:0] nx,
                                          input logic [ACC_W-1:0] ny,
                                          input logic sx, input logic sy,
                                          input logic sh);
        t_odo_word w;
        w.func = func;
        w.lp   = lp;
        w.rp   = rp;
        w.hd   = hd;
        w.nx   = nx;
        w.ny   = ny;
        w.sx   = sx;
        w.sy   = sy;
        w.sh   = sh;
        return w;
    endfunction

    function automatic t_odo_word tick_word(input logic [POS_IN_W-1:0] lp,
                                            input logic [POS_IN_W-1:0] rp,
                                            input int hd);
        return mk_word(FUNC_TICK, lp, rp, hd[HEAD_W-1:0], $urandom, $urandom,
                       1'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    // Mostly ticks with smooth motion; the rest sets, zeros, jumps and noise
    function automatic t_odo_word random_word();
        t_odo_word w;
        int        pick;
        int        kind;
        int        hd_val;
        w = mk_word(FUNC_W'($urandom), $urandom, $urandom, HEAD_W'($urandom),
                    $urandom, $urandom, 1'($urandom), 1'($urandom), 1'($urandom));
        pick = $urandom_range(99);
        if (pick < 75) begin
            w.func = FUNC_TICK;
            kind   = $urandom_range(99);
            if (kind < 80) begin
                enc_left  = enc_left + POS_IN_W'($urandom_range(4000)) - 32'd2000;
                enc_right = enc_right + POS_IN_W'($urandom_range(4000)) - 32'd2000;
            end else if (kind < 90) begin
                enc_left  = $urandom;
                enc_right = $urandom;
            end else begin
                // park near the extremes so sums wrap
                enc_left  = 32'h7FFF_FC00 + POS_IN_W'($urandom_range(2047));
                enc_right = 32'h7FFF_FC00 + POS_IN_W'($urandom_range(2047));
            end
            w.lp = enc_left;
            w.rp = enc_right;
            if ($urandom_range(99) < 85) begin
                hd_val = int'($urandom_range(23040)) - 11520;
                w.hd   = hd_val[HEAD_W-1:0];
            end
        end else if (pick < 87) begin
            w.func = FUNC_SET;
        end else if (pick < 95) begin
            w.func = FUNC_ZERO;
            if ($urandom_range(3) != 0) begin
                w.lp = enc_left;
                w.rp = enc_right;
            end
        end else begin
            w.func = FUNC_SPARE;
        end
        return w;
    endfunction

    //------------------------------------------------------------------
    // Driving
    //------------------------------------------------------------------

    // Offer one word after a random gap; predict it on acceptance
    task automatic send_word(input t_odo_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.func           <= w.func;
        in_ch.left_position  <= w.lp;
        in_ch.right_position <= w.rp;
        in_ch.heading        <= w.hd;
        in_ch.new_x          <= w.nx;
        in_ch.new_y          <= w.ny;
        in_ch.set_x          <= w.sx;
        in_ch.set_y          <= w.sy;
        in_ch.set_heading    <= w.sh;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        pending_poses.push_back(advance_pose(w));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every pose word has come back
    task automatic settle_idle();
        in_ch.valid <= 1'b0;
        while (pending_poses.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        settle_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        scale_model  = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested
    initial begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request > 0) begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    //------------------------------------------------------------------
    // Checking: compare each pose word with the oldest prediction
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pose want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_poses.size() == 0) begin
                if (pose_mismatches < 10)
                    $display("unexpected pose word: x=%0d y=%0d heading=%0d",
                             out_ch.x_pos, out_ch.y_pos, out_ch.heading_out);
                pose_mismatches++;
            end else begin
                want = pending_poses.pop_front();
                if (out_ch.x_pos !== want.x || out_ch.y_pos !== want.y ||
                    out_ch.heading_out !== want.hd) begin
                    if (pose_mismatches < 10)
                        $display("pose mismatch: x %0d/%0d y %0d/%0d heading %0d/%0d",
                                 $signed(want.x), out_ch.x_pos,
                                 $signed(want.y), out_ch.y_pos,
                                 $signed(want.hd), out_ch.heading_out);
                    pose_mismatches++;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Extremes of every field, each function and every fold of the heading
    task automatic test_directed();
        set_idling(0, 0);
        send_word(tick_word(32'd0, 32'd0, 0));
        send_word(tick_word(32'd1000, 32'd1200, 0));
        send_word(tick_word(32'd5000, 32'd5000, 5760));
        send_word(tick_word(32'd9000, 32'd9000, -5760));
        send_word(tick_word(32'd12000, 32'd12000, 11520));
        send_word(tick_word(32'd15000, 32'd15000, -11520));
        send_word(tick_word(32'd18000, 32'd20000, 5761));
        send_word(tick_word(32'd20000, 32'd22000, -5761));
        // headings beyond a half turn: fold for trig, store as given
        send_word(tick_word(32'd21000, 32'd23000, 16383));
        send_word(tick_word(32'd22000, 32'd25000, -16384));
        // huge positive change saturates, then the sum wraps by a small step
        send_word(tick_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 2000));
        send_word(tick_word(32'h8000_0000, 32'h8000_0000, -3000));
        // huge negative change saturates
        send_word(mk_word(FUNC_ZERO, 32'd0, 32'd0, 15'd0, 32'd0, 32'd0,
                          1'b1, 1'b1, 1'b1));
        send_word(tick_word(32'h8000_0000, 32'h8000_0000, -3000));
        // offset at the top of the range, change across the wrap
        send_word(mk_word(FUNC_ZERO, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 15'h7FFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
        send_word(tick_word(32'h8000_0000, 32'h8000_0000, 4000));
        // set every part, then wrap x with a large step
        send_word(mk_word(FUNC_SET, $urandom, $urandom, 15'd11520,
                          32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b1));
        send_word(tick_word(32'h4000_0000, 32'h4000_0000, -5760));
        send_word(mk_word(FUNC_SET, $urandom, $urandom, 15'h1234,
                          32'h1111_1111, 32'h2222_2222, 1'b0, 1'b0, 1'b0));
        send_word(mk_word(FUNC_SET, $urandom, $urandom, 15'h0F0F,
                          32'h8000_0000, 32'h0, 1'b1, 1'b0, 1'b0));
        send_word(mk_word(FUNC_SET, $urandom, $urandom, 15'h0F0F,
                          32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0));
        send_word(mk_word(FUNC_SET, $urandom, $urandom, 15'h4000,
                          32'h0, 32'h0, 1'b0, 1'b0, 1'b1));
        send_word(mk_word(FUNC_SPARE, $urandom, $urandom, HEAD_W'($urandom),
                          $urandom, $urandom, 1'b1, 1'b1, 1'b1));
        // later ticks use their own heading, not the one set
        send_word(tick_word(32'h4000_1000, 32'h4000_0800, 300));
        send_word(mk_word(FUNC_ZERO, $urandom, $urandom, HEAD_W'($urandom),
                          $urandom, $urandom, 1'($urandom), 1'($urandom), 1'b1));
        send_word(tick_word(32'd777, 32'd333, -1000));
    endtask

    // Walk the scale through its extremes with traffic at each setting
    task automatic test_scale_sweep();
        logic [SCALE_W-1:0] scales [5];
        int s;
        int n;
        scales = '{16'd0, 16'hFFFF, 16'd1, SCALE_W'($urandom), SCALE_RESET};
        set_idling(0, 0);
        for (s = 0; s < 5; s++) begin
            write_scale(scales[s]);
            for (n = 0; n < 12; n++) send_word(random_word());
        end
    endtask

    // Random traffic under each idling pattern, new scale per phase
    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < 4; phase++) begin
            write_scale(SCALE_W'($urandom));
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(69, 0);
                2: set_idling(0, 69);
                default: set_idling(11, 11);
            endcase
            for (n = 0; n < 250; n++) send_word(random_word());
        end
    endtask

    // Hold the receiver off while words keep coming, so the input stalls
    task automatic test_output_stall();
        int n;
        settle_idle();
        set_idling(0, 0);
        stall_request = STALL_LONG;
        for (n = 0; n < 20; n++) send_word(random_word());
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        in_ch.valid          = 1'b0;
        in_ch.func           = FUNC_TICK;
        in_ch.left_position  = '0;
        in_ch.right_position = '0;
        in_ch.heading        = '0;
        in_ch.new_x          = '0;
        in_ch.new_y          = '0;
        in_ch.set_x          = 1'b0;
        in_ch.set_y          = 1'b0;
        in_ch.set_heading    = 1'b0;

        scale_model     = SCALE_RESET;
        x_model         = '0;
        y_model         = '0;
        heading_model   = '0;
        last_sum        = '0;
        base_sum        = '0;
        enc_left        = '0;
        enc_right       = '0;
        pose_mismatches = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        stall_request   = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_scale_sweep();
        test_random_traffic();
        test_output_stall();

        // drain, then give stray words time to show up
        settle_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pose_mismatches == 0 && pending_poses.size() == 0) begin
            $display("encoder_heading_odometry_unit verification clean");
        end else begin
            $display("encoder_heading_odometry_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
